@@ rtl/psu_read_ein_average_power_top_defines.svh @@
// Assertion helpers shared by the block's modules.
`ifndef PSU_READ_EIN_AVERAGE_POWER_TOP_DEFINES_SVH
`define PSU_READ_EIN_AVERAGE_POWER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define PSURP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PSURP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/psurp_pkg.sv @@
`timescale 1ns / 1ps
package psurp_pkg;

   localparam int ACC_W    = 23;
   localparam int CNT_W    = 24;
   localparam int CAP_W    = 16;
   localparam int LIM_W    = 4;
   localparam int PWR_W    = 19;
   localparam int NODE_W   = 20;
   localparam int PROD_W   = CAP_W + CNT_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int PWR_MAX  = 2 ** (PWR_W - 1) - 1;

   localparam logic [CSR_IDX_W-1:0] CSR_POWER_CAP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIM_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIM_B = 2'd2;

   localparam logic [CAP_W-1:0] CAP_RESET   = 16'd1000;
   localparam logic [LIM_W-1:0] LIM_A_RESET = 4'd6;
   localparam logic [LIM_W-1:0] LIM_B_RESET = 4'd7;
   localparam logic [LIM_W-1:0] READS_MAX   = 4'd15;
   localparam logic [6:0]       ACC_HIGH_MASK = 7'h7f;

   typedef struct packed {
      logic capture;
      logic delta;
      logic mult;
      logic compare;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic skip_div;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/psu_read_ein_average_power_top.sv @@
// Flow: an accepted item passes the DELTA, MULT and CMP states; a failed read, bad delta
// or over cap skips the division, otherwise DIVIDE runs the bit-serial divider first.
// FINISH waits for a free output register; no new item is taken until the controller is back in IDLE.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears history, round read count and registers to defaults.
`timescale 1ns / 1ps
module psu_read_ein_average_power_top
   import psurp_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_new_round,
   input  logic                     req_psu_sel,
   input  logic                     req_read_ok,
   input  logic [7:0]               req_acc_low,
   input  logic [7:0]               req_acc_high,
   input  logic [7:0]               req_rollover,
   input  logic [7:0]               req_count_low,
   input  logic [7:0]               req_count_mid,
   input  logic [7:0]               req_count_high,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [PWR_W-1:0]  rsp_psu_power,
   output logic                     rsp_read_error,
   output logic                     rsp_retry,
   output logic                     rsp_round_done,
   output logic signed [NODE_W-1:0] rsp_combined_power
);

   cmd_type cmd;
   sts_type sts;

   psurp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   psurp_dp #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_new_round      (req_new_round),
      .req_psu_sel        (req_psu_sel),
      .req_read_ok        (req_read_ok),
      .req_acc_low        (req_acc_low),
      .req_acc_high       (req_acc_high),
      .req_rollover       (req_rollover),
      .req_count_low      (req_count_low),
      .req_count_mid      (req_count_mid),
      .req_count_high     (req_count_high),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_psu_power      (rsp_psu_power),
      .rsp_read_error     (rsp_read_error),
      .rsp_retry          (rsp_retry),
      .rsp_round_done     (rsp_round_done),
      .rsp_combined_power (rsp_combined_power)
   );

endmodule

@@ rtl/psurp_div.sv @@
`timescale 1ns / 1ps
module psurp_div
   import psurp_pkg::*;
#(
   parameter int DIVIDEND_W = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [CNT_W-1:0]      divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   localparam int SW = $clog2(DIVIDEND_W + 1);
   localparam logic [SW-1:0] STEPS = SW'(DIVIDEND_W);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      dsr_ff, dsr_in;
   logic [SW-1:0]         steps_ff, steps_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W:0]        shifted;
   logic [CNT_W:0]        trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         steps_in = STEPS;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // restoring step: keep the trial remainder when it did not go negative
         if (!trial[CNT_W]) begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[CNT_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         steps_in = steps_ff - SW'(1);
         if (steps_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      steps_ff <= steps_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

`include "psu_read_ein_average_power_top_defines.svh"

   `PSURP_ASSERT_IMP(a_done_after_busy, clock, reset, done_ff, !busy_ff, "divider done while busy")

endmodule

@@ rtl/psurp_dp.sv @@
`timescale 1ns / 1ps
module psurp_dp
   import psurp_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_wdata,
   input  logic                     req_new_round,
   input  logic                     req_psu_sel,
   input  logic                     req_read_ok,
   input  logic [7:0]               req_acc_low,
   input  logic [7:0]               req_acc_high,
   input  logic [7:0]               req_rollover,
   input  logic [7:0]               req_count_low,
   input  logic [7:0]               req_count_mid,
   input  logic [7:0]               req_count_high,
   input  cmd_type                  cmd,
   output sts_type                  sts,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [PWR_W-1:0]  rsp_psu_power,
   output logic                     rsp_read_error,
   output logic                     rsp_retry,
   output logic                     rsp_round_done,
   output logic signed [NODE_W-1:0] rsp_combined_power
);

   localparam int DIVW = ACC_W + FRAC_BITS;
   localparam logic [PWR_W-1:0] PWR_SENTINEL = PWR_W'(0) - (PWR_W'(1) << FRAC_BITS);

   logic [CAP_W-1:0] cap_ff;
   logic [LIM_W-1:0] lim_a_ff;
   logic [LIM_W-1:0] lim_b_ff;

   logic             sel_ff, sel_in;
   logic             ok_ff, ok_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LIM_W-1:0] reads_ff, reads_in;
   logic [ACC_W-1:0] prev_acc_ff [2];
   logic [CNT_W-1:0] prev_cnt_ff [2];
   logic [ACC_W-1:0] d1_ff, d1_in;
   logic [CNT_W-1:0] d2_ff, d2_in;
   logic             bad_ff, bad_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic             over_ff, over_in;
   logic             over_now;
   logic [PWR_W-1:0] held_a_ff, held_a_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PWR_W-1:0]  pwr_ff, pwr_in;
   logic              err_ff, err_in;
   logic              retry_ff, retry_in;
   logic              done_ff, done_in;
   logic [NODE_W-1:0] node_ff, node_in;

   logic [DIVW-1:0]   quotient;
   logic              div_done;
   logic [LIM_W-1:0]  limit;
   logic [ACC_W-1:0]  pa;
   logic [CNT_W-1:0]  pc;

   psurp_div #(
      .DIVIDEND_W(DIVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (DIVW'(d1_ff) << FRAC_BITS),
      .divisor  (d2_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         lim_a_ff <= LIM_A_RESET;
         lim_b_ff <= LIM_B_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POWER_CAP:   cap_ff   <= csr_wdata[CAP_W-1:0];
            CSR_RETRY_LIM_A: lim_a_ff <= csr_wdata[LIM_W-1:0];
            CSR_RETRY_LIM_B: lim_b_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign pa       = prev_acc_ff[sel_ff];
   assign pc       = prev_cnt_ff[sel_ff];
   assign over_now = PROD_W'(d1_ff) > prod_ff;
   assign limit    = sel_ff ? lim_b_ff : lim_a_ff;

   always_comb begin
      sel_in       = sel_ff;
      ok_in        = ok_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      reads_in     = reads_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      bad_in       = bad_ff;
      prod_in      = prod_ff;
      over_in      = over_ff;
      held_a_in    = held_a_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pwr_in       = pwr_ff;
      err_in       = err_ff;
      retry_in     = retry_ff;
      done_in      = done_ff;
      node_in      = node_ff;

      if (cmd.capture) begin
         sel_in = req_psu_sel;
         ok_in  = req_read_ok;
         acc_in = {req_rollover, req_acc_high[6:0] & ACC_HIGH_MASK, req_acc_low};
         cnt_in = {req_count_high, req_count_mid, req_count_low};
         if (req_new_round) begin
            reads_in = LIM_W'(1);
         end else if (reads_ff != READS_MAX) begin
            reads_in = reads_ff + LIM_W'(1);
         end
      end

      if (cmd.delta) begin
         d1_in  = acc_ff - pa;
         d2_in  = cnt_ff - pc;
         bad_in = (acc_ff < pa) || (cnt_ff <= pc);
      end

      if (cmd.mult) begin
         prod_in = PROD_W'(cap_ff) * PROD_W'(d2_ff);
      end

      if (cmd.compare) begin
         over_in = over_now;
      end

      if (cmd.load_out) begin
         err_in = !ok_ff || bad_ff;
         if (err_in) begin
            pwr_in = '0;
         end else if (over_ff) begin
            pwr_in = PWR_SENTINEL;
         end else if (quotient > DIVW'(PWR_MAX)) begin
            pwr_in = PWR_W'(PWR_MAX);
         end else begin
            pwr_in = quotient[PWR_W-1:0];
         end
         retry_in = err_in && (reads_ff <= limit);
         done_in  = sel_ff && !retry_in;
         node_in  = done_in ? ({held_a_ff[PWR_W-1], held_a_ff} + {pwr_in[PWR_W-1], pwr_in})
                            : '0;
         if (!sel_ff) begin
            held_a_in = pwr_in;
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff  <= sel_in;
      ok_ff   <= ok_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      bad_ff  <= bad_in;
      prod_ff <= prod_in;
      over_ff <= over_in;
      pwr_ff   <= pwr_in;
      err_ff   <= err_in;
      retry_ff <= retry_in;
      done_ff  <= done_in;
      node_ff  <= node_in;
      if (reset) begin
         reads_ff       <= '0;
         held_a_ff      <= '0;
         prev_acc_ff[0] <= '0;
         prev_acc_ff[1] <= '0;
         prev_cnt_ff[0] <= '0;
         prev_cnt_ff[1] <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         reads_ff     <= reads_in;
         held_a_ff    <= held_a_in;
         rsp_valid_ff <= rsp_valid_in;
         // a failed read leaves the supply's history alone
         if (cmd.delta && ok_ff) begin
            prev_acc_ff[sel_ff] <= acc_ff;
            prev_cnt_ff[sel_ff] <= cnt_ff;
         end
      end
   end

   assign sts.skip_div = !ok_ff || bad_ff || over_now;
   assign sts.div_done = div_done;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_psu_power      = pwr_ff;
   assign rsp_read_error     = err_ff;
   assign rsp_retry          = retry_ff;
   assign rsp_round_done     = done_ff;
   assign rsp_combined_power = node_ff;

`include "psu_read_ein_average_power_top_defines.svh"

   `PSURP_ASSERT_IMP(a_node_only_when_done, clock, reset, rsp_valid_ff && !done_ff, node_ff == '0, "combined power without round done")
   `PSURP_ASSERT_IMP(a_retry_needs_error, clock, reset, rsp_valid_ff && retry_ff, err_ff && !done_ff, "retry without error")

endmodule

@@ rtl/psurp_ctrl.sv @@
`timescale 1ns / 1ps
module psurp_ctrl
   import psurp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DELTA,
      MULT,
      CMP,
      DIVIDE,
      FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = DELTA;
         end
         DELTA: begin
            cmd.delta = 1'b1;
            state_in  = MULT;
         end
         MULT: begin
            cmd.mult = 1'b1;
            state_in = CMP;
         end
         CMP: begin
            cmd.compare = 1'b1;
            if (sts.skip_div) begin
               state_in = FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = DIVIDE;
            end
         end
         DIVIDE: begin
            if (sts.div_done) state_in = FINISH;
         end
         FINISH: begin
            // hold the result until the output register can take it
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == IDLE);

`include "psu_read_ein_average_power_top_defines.svh"

   `PSURP_ASSERT_IMP(a_div_done_in_divide, clock, reset, sts.div_done, state_ff == DIVIDE, "divider finished outside divide state")
   `PSURP_ASSERT_NXT(a_capture_blocks_next, clock, reset, cmd.capture, !req_ready && !cmd.load_out, "second transfer while busy")

endmodule

@@ dv/tb_psu_read_ein_average_power_top.sv @@
`timescale 1ns / 1ps
module tb_psu_read_ein_average_power_top;
   import psurp_pkg::*;

   localparam int FRAC_BITS     = 8;
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_ITEMS   = 230;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [PWR_W-1:0] PWR_OVER_CAP = PWR_W'(-(1 << FRAC_BITS));

   typedef struct packed {
      logic       new_round;
      logic       psu_sel;
      logic       read_ok;
      logic [7:0] acc_low;
      logic [7:0] acc_high;
      logic [7:0] rollover;
      logic [7:0] count_low;
      logic [7:0] count_mid;
      logic [7:0] count_high;
   } ein_read_type;

   typedef struct packed {
      logic [PWR_W-1:0]  psu_power;
      logic              read_error;
      logic              retry;
      logic              round_done;
      logic [NODE_W-1:0] combined_power;
   } ein_power_type;

   typedef enum int {RD_GOOD, RD_FAIL, RD_STALE, RD_DROP_ACC, RD_DROP_CNT, RD_NOISE} read_kind_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DAT_W-1:0]     csr_wdata = '0;
   logic                     req_valid = 1'b0;
   wire                      req_ready;
   ein_read_type             req_item  = '0;
   wire                      rsp_valid;
   logic                     rsp_ready = 1'b0;
   wire signed [PWR_W-1:0]   rsp_psu_power;
   wire                      rsp_read_error;
   wire                      rsp_retry;
   wire                      rsp_round_done;
   wire signed [NODE_W-1:0]  rsp_combined_power;

   // Predictor state and its copy of the registers
   logic [CAP_W-1:0] cap_watts      = CAP_RESET;
   logic [LIM_W-1:0] lim_a          = LIM_A_RESET;
   logic [LIM_W-1:0] lim_b          = LIM_B_RESET;
   logic [ACC_W-1:0] last_acc [2]   = '{default: '0};
   logic [CNT_W-1:0] last_cnt [2]   = '{default: '0};
   logic [PWR_W-1:0] held_a_power   = '0;
   logic [LIM_W-1:0] reads_in_round = '0;

   // Generator view of what each supply last stored
   logic [ACC_W-1:0] gen_acc [2] = '{default: '0};
   logic [CNT_W-1:0] gen_cnt [2] = '{default: '0};

   ein_read_type  ein_read_q[$];
   ein_power_type power_expected_q[$];

   int   items_queued   = 0;
   int   items_accepted = 0;
   int   src_idle_max   = 18;
   int   sink_idle_max  = 18;
   int   src_gap        = 0;
   int   sink_gap       = 0;
   logic hold_rsp       = 1'b0;

   int mismatch_cnt   = 0;
   int results_seen   = 0;
   int errors_seen    = 0;
   int retries_seen   = 0;
   int rounds_seen    = 0;
   int over_cap_seen  = 0;
   int saturated_seen = 0;
   int settings_used  = 0;

   psu_read_ein_average_power_top #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_new_round      (req_item.new_round),
      .req_psu_sel        (req_item.psu_sel),
      .req_read_ok        (req_item.read_ok),
      .req_acc_low        (req_item.acc_low),
      .req_acc_high       (req_item.acc_high),
      .req_rollover       (req_item.rollover),
      .req_count_low      (req_item.count_low),
      .req_count_mid      (req_item.count_mid),
      .req_count_high     (req_item.count_high),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_psu_power      (rsp_psu_power),
      .rsp_read_error     (rsp_read_error),
      .rsp_retry          (rsp_retry),
      .rsp_round_done     (rsp_round_done),
      .rsp_combined_power (rsp_combined_power)
   );

   always #5 clock = ~clock;

   function automatic ein_power_type predict_ein_power(input ein_read_type rd);
      logic [ACC_W-1:0] acc;
      logic [CNT_W-1:0] cnt;
      logic [63:0]      d_acc;
      logic [63:0]      d_cnt;
      logic [63:0]      quot;
      logic [LIM_W-1:0] lim;
      ein_power_type    r;
      acc = {rd.rollover, rd.acc_high[6:0], rd.acc_low};
      cnt = {rd.count_high, rd.count_mid, rd.count_low};
      r   = '0;
      if (rd.new_round) begin
         reads_in_round = LIM_W'(1);
      end else if (reads_in_round != READS_MAX) begin
         reads_in_round++;
      end
      if (!rd.read_ok) begin
         r.read_error = 1'b1;
      end else begin
         if (acc < last_acc[rd.psu_sel] || cnt <= last_cnt[rd.psu_sel]) begin
            r.read_error = 1'b1;
         end else begin
            d_acc = 64'(acc) - 64'(last_acc[rd.psu_sel]);
            d_cnt = 64'(cnt) - 64'(last_cnt[rd.psu_sel]);
            // cap check on the exact quotient, before any truncation
            if (d_acc > 64'(cap_watts) * d_cnt) begin
               r.psu_power = PWR_OVER_CAP;
            end else begin
               quot = (d_acc << FRAC_BITS) / d_cnt;
               r.psu_power = (quot > PWR_MAX) ? PWR_W'(PWR_MAX) : quot[PWR_W-1:0];
            end
         end
         last_acc[rd.psu_sel] = acc;
         last_cnt[rd.psu_sel] = cnt;
      end
      lim     = rd.psu_sel ? lim_b : lim_a;
      r.retry = r.read_error && (reads_in_round <= lim);
      if (!rd.psu_sel) begin
         held_a_power = r.psu_power;
      end else if (!r.retry) begin
         r.round_done     = 1'b1;
         r.combined_power = {held_a_power[PWR_W-1], held_a_power}
                          + {r.psu_power[PWR_W-1], r.psu_power};
      end
      return r;
   endfunction

   function automatic ein_read_type make_read(input logic newr, input logic sel, input logic ok,
                                              input logic [ACC_W-1:0] acc,
                                              input logic [CNT_W-1:0] cnt);
      ein_read_type r;
      r.new_round = newr;
      r.psu_sel   = sel;
      r.read_ok   = ok;
      r.acc_low   = acc[7:0];
      r.acc_high  = {1'($urandom_range(0, 1)), acc[14:8]};
      r.rollover  = acc[22:15];
      {r.count_high, r.count_mid, r.count_low} = cnt;
      if (ok) begin
         gen_acc[sel] = acc;
         gen_cnt[sel] = cnt;
      end
      return r;
   endfunction

   function automatic ein_read_type build_read(input logic newr, input logic sel,
                                               input read_kind_type kind);
      logic [63:0]      d_cnt;
      logic [63:0]      d_acc;
      logic [63:0]      watts;
      logic [ACC_W-1:0] acc;
      logic [CNT_W-1:0] cnt;
      acc = gen_acc[sel];
      cnt = gen_cnt[sel];
      case (kind)
         RD_GOOD: begin
            d_cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1 << 20)
                                                 : $urandom_range(1, 64);
            case ($urandom_range(0, 9))
               6:       watts = cap_watts;
               7:       watts = $urandom_range(0, 70000);
               8:       watts = 0;
               9:       watts = cap_watts + 1;
               default: watts = $urandom_range(0, 1100);
            endcase
            d_acc = watts * d_cnt;
            if ($urandom_range(0, 3) != 0) d_acc += $urandom_range(0, d_cnt - 1);
            // sums that overflow wrap and so show up as drops
            return make_read(newr, sel, 1'b1, ACC_W'(acc + d_acc), CNT_W'(cnt + d_cnt));
         end
         RD_FAIL:
            return make_read(newr, sel, 1'b0, ACC_W'($urandom), CNT_W'($urandom));
         RD_STALE:
            return make_read(newr, sel, 1'b1, ACC_W'(acc + $urandom_range(0, 255)), cnt);
         RD_DROP_ACC:
            return make_read(newr, sel, 1'b1,
                             (acc == 0) ? '0 : ACC_W'($urandom_range(0, acc - 1)),
                             CNT_W'(cnt + 1));
         RD_DROP_CNT:
            return make_read(newr, sel, 1'b1, ACC_W'(acc + 1),
                             (cnt == 0) ? '0 : CNT_W'($urandom_range(0, cnt - 1)));
         default:
            return make_read(newr, sel, 1'($urandom_range(0, 1)),
                             ACC_W'($urandom), CNT_W'($urandom));
      endcase
   endfunction

   task automatic queue_read(input ein_read_type r);
      ein_read_q.push_back(r);
      items_queued++;
   endtask

   // One sampling round: A then B, each with a run of zero or more bad reads before a good one
   task automatic queue_round();
      int            errs;
      logic          first;
      read_kind_type kind;
      first = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 9) == 0) begin
         queue_read(build_read(first, 1'($urandom_range(0, 1)), RD_NOISE));
         first = 1'b0;
      end
      for (int s = 0; s < 2; s++) begin
         case ($urandom_range(0, 19))
            14, 15, 16, 17: errs = $urandom_range(1, 3);
            18:             errs = $urandom_range(4, 8);
            19:             errs = $urandom_range(9, 18);
            default:        errs = 0;
         endcase
         for (int k = 0; k < errs; k++) begin
            kind = read_kind_type'($urandom_range(RD_FAIL, RD_DROP_CNT));
            queue_read(build_read(first, s[0], kind));
            first = 1'b0;
         end
         // now and then let supply B finish the round on a bad read
         if (!(s == 1 && errs > 0 && $urandom_range(0, 4) == 0)) begin
            queue_read(build_read(first, s[0], RD_GOOD));
            first = 1'b0;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_POWER_CAP:   cap_watts = val;
         CSR_RETRY_LIM_A: lim_a     = val[LIM_W-1:0];
         CSR_RETRY_LIM_B: lim_b     = val[LIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input int cap, input int la, input int lb);
      write_csr(CSR_POWER_CAP, CSR_DAT_W'(cap));
      write_csr(CSR_RETRY_LIM_A, CSR_DAT_W'(la));
      write_csr(CSR_RETRY_LIM_B, CSR_DAT_W'(lb));
      settings_used++;
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || power_expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: hold each item until its transfer, then wait the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            power_expected_q.push_back(predict_ein_power(req_item));
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_valid <= 1'b0;
            end else if (ein_read_q.size() > 0) begin
               req_item  <= ein_read_q.pop_front();
               req_valid <= 1'b1;
               src_gap = $urandom_range(0, src_idle_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker
   always @(posedge clock) begin : rsp_sink
      ein_power_type want;
      ein_power_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_psu_power, rsp_read_error, rsp_retry, rsp_round_done,
                   rsp_combined_power};
            results_seen++;
            if (power_expected_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("%0t: result %0d arrived with nothing outstanding", $realtime,
                           results_seen);
            end else begin
               want = power_expected_q.pop_front();
               errors_seen    += want.read_error;
               retries_seen   += want.retry;
               rounds_seen    += want.round_done;
               over_cap_seen  += (want.psu_power == PWR_OVER_CAP);
               saturated_seen += (want.psu_power == PWR_W'(PWR_MAX));
               if (got !== want) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display({"%0t: result %0d mismatch: expected pwr %0d err %0b retry %0b",
                               " done %0b sum %0d, got pwr %0d err %0b retry %0b done %0b",
                               " sum %0d"}, $realtime, results_seen,
                              $signed(want.psu_power), want.read_error, want.retry,
                              want.round_done, $signed(want.combined_power),
                              $signed(got.psu_power), got.read_error, got.retry,
                              got.round_done, $signed(got.combined_power));
               end
            end
            sink_gap = $urandom_range(0, sink_idle_max);
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Back-pressure: stall the result side long enough for the block to fill up
   initial begin
      while (items_accepted < 300) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #6_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers
      queue_read(make_read(1'b1, 1'b0, 1'b1, 0, 0));                   // zero count delta
      queue_read(make_read(1'b0, 1'b0, 1'b1, 23'h7FFFFF, 1));          // over cap
      queue_read(make_read(1'b0, 1'b1, 1'b0, ACC_W'($urandom), CNT_W'($urandom)));
      queue_read(make_read(1'b0, 1'b1, 1'b1, 5000, 5));                // exactly at cap
      queue_read(make_read(1'b1, 1'b0, 1'b1, 23'h7FFFFF, 4));          // zero energy
      queue_read(make_read(1'b0, 1'b0, 1'b1, 'h10, 10));               // accumulator drop
      queue_read(make_read(1'b0, 1'b0, 1'b1, 'h20, 9));                // count drop
      queue_read(make_read(1'b0, 1'b0, 1'b1, 'h2A, 12));               // truncated quotient
      queue_read(make_read(1'b0, 1'b1, 1'b1, 5000, 5));
      queue_read(make_read(1'b0, 1'b1, 1'b1, 5007, 8));
      queue_read(make_read(1'b1, 1'b1, 1'b1, 23'h7FFFFF, 24'hFFFFFF)); // largest values
      queue_read(make_read(1'b0, 1'b1, 1'b0, ACC_W'($urandom), CNT_W'($urandom)));
      wait_idle();

      set_registers(65535, 0, 15);
      queue_read(make_read(1'b1, 1'b0, 1'b1, 'h2A + 2000, 13));        // saturates
      queue_read(make_read(1'b0, 1'b1, 1'b1, 23'h7FFFFF, 24'hFFFFFF));
      queue_read(make_read(1'b0, 1'b0, 1'b0, ACC_W'($urandom), CNT_W'($urandom)));
      queue_read(make_read(1'b0, 1'b1, 1'b1, 0, 0));
      queue_read(make_read(1'b0, 1'b1, 1'b1, 65535, 1));
      queue_read(make_read(1'b0, 1'b1, 1'b1, 65535 + 65536, 2));
      wait_idle();

      set_registers(0, 6, 7);
      queue_read(make_read(1'b1, 1'b0, 1'b1, 'h2A + 2000, 14));
      queue_read(make_read(1'b0, 1'b0, 1'b1, 'h2A + 2001, 15));
      queue_read(make_read(1'b0, 1'b1, 1'b1, 65535 + 65536, 3));
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               set_registers(1000, 6, 7);
               src_idle_max = 18; sink_idle_max = 18;
            end
            1: begin
               set_registers(0, 0, 0);
               src_idle_max = 0; sink_idle_max = 0;
            end
            2: begin
               set_registers(65535, 15, 15);
               src_idle_max = 18; sink_idle_max = 0;
            end
            3: begin
               set_registers($urandom_range(0, 65535), $urandom_range(0, 15),
                             $urandom_range(0, 15));
               src_idle_max = 0; sink_idle_max = 18;
            end
            4: begin
               set_registers(1, $urandom_range(0, 15), $urandom_range(0, 15));
               src_idle_max = 18; sink_idle_max = 18;
            end
            default: begin
               set_registers($urandom_range(500, 1500), $urandom_range(0, 15),
                             $urandom_range(0, 15));
               src_idle_max = 18; sink_idle_max = 18;
            end
         endcase
         target = items_queued + PHASE_ITEMS;
         while (items_queued < target) queue_round();
         wait_idle();
      end

      if (power_expected_q.size() != 0) begin
         mismatch_cnt += power_expected_q.size();
         $display("%0d results never arrived", power_expected_q.size());
      end
      $display("checked %0d results under %0d register settings: %0d read errors, %0d retries",
               results_seen, settings_used, errors_seen, retries_seen);
      $display("%0d rounds completed, %0d over-cap results, %0d saturated results",
               rounds_seen, over_cap_seen, saturated_seen);
      if (mismatch_cnt == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/psurp_pkg.sv
rtl/psurp_div.sv
rtl/psurp_dp.sv
rtl/psurp_ctrl.sv
rtl/psu_read_ein_average_power_top.sv
dv/tb_psu_read_ein_average_power_top.sv
